// ===== sv/pid_controller_step_assert.svh =====
// assertion macros shared by the pid controller step modules
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PIDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pidc_pkg.sv =====
// shared types and constants of the pid controller step
package pidc_pkg;

    // multiplier slicing: one signed 32x32 product per cycle
    localparam int MUL_CW = 31;
    localparam int MUL_BW = 32;

    // fixed field widths
    localparam int GAIN_W    = 32;
    localparam int SCALE_W   = 31;
    localparam int CFG_IDX_W = 3;

    // integer part of the upper limit after reset (65535.0)
    localparam logic [15:0] LIM_HI_RST_INT = 16'hffff;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP     = 3'd0,
        REG_GAIN_INTEG    = 3'd1,
        REG_GAIN_DERIV    = 3'd2,
        REG_LIMIT_LOW     = 3'd3,
        REG_LIMIT_HIGH    = 3'd4,
        REG_POSITION_MODE = 3'd5,
        REG_DEADBAND      = 3'd6,
        REG_COUNT_SCALE   = 3'd7
    } t_reg_idx;

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MS_CUR = 3'd0,
        MS_OLD = 3'd1,
        MS_INT = 3'd2,
        MS_PRO = 3'd3,
        MS_DER = 3'd4
    } t_mul_sel;

    // controller states
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_W_CUR = 9'b000000010,
        S_W_OLD = 9'b000000100,
        S_ERR   = 9'b000001000,
        S_W_INT = 9'b000010000,
        S_W_PRO = 9'b000100000,
        S_W_DER = 9'b001000000,
        S_SUM   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     cap_cur;
        logic     cap_old;
        logic     cap_err;
        logic     cap_integ;
        logic     cap_prop;
        logic     cap_deriv;
        logic     clear_acc;
        logic     finish;
        logic     load_out;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic mul_done;
        logic enable;
        logic pos_mode;
        logic err_zero;
    } t_dp_status;

endpackage

// ===== sv/pidc_mul.sv =====
// sliced signed multiplier: value operand times 32-bit operand, one slice a cycle
`include "pid_controller_step_assert.svh"

module pidc_mul #(
    parameter int A_W = 40
) (
    i_clk,
    i_rst_n,
    i_start,
    i_a,
    i_b,
    o_done,
    o_prod
);
    localparam int CW    = pidc_pkg::MUL_CW;
    localparam int BW    = pidc_pkg::MUL_BW;
    localparam int NCH   = (A_W + CW - 1) / CW;
    localparam int AP    = NCH * CW;
    localparam int PW    = AP + BW;
    localparam int CNT_W = $clog2(NCH + 1);

    input  logic                  i_clk;
    input  logic                  i_rst_n;
    input  logic                  i_start;
    input  logic signed [A_W-1:0] i_a;
    input  logic signed [BW-1:0]  i_b;
    output logic                  o_done;
    output logic signed [PW-1:0]  o_prod;

    logic signed [AP-1:0]     r_a;
    logic signed [BW-1:0]     r_b;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [2*BW-1:0]   r_pp;
    logic                     r_pp_v;
    logic                     r_pp_last;
    logic signed [PW-1:0]     r_acc;
    logic                     r_done;

    logic signed [AP-1:0]     w_a_ext;
    logic [CW-1:0]            w_chunk;
    logic signed [BW-1:0]     w_chunk_ext;
    logic signed [2*BW-1:0]   w_pp;
    logic                     w_first;
    logic                     w_busy;

    assign w_a_ext = AP'(i_a);

    // top slice is signed, lower slices are plain magnitudes
    assign w_chunk     = r_a[AP-1 -: CW];
    assign w_first     = (r_cnt == CNT_W'(NCH));
    assign w_chunk_ext = w_first ? $signed({w_chunk[CW-1], w_chunk})
                                 : $signed({1'b0, w_chunk});
    assign w_pp        = w_chunk_ext * r_b;
    assign w_busy      = (r_cnt != '0) || r_pp_v;

    // slice control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_pp_v    <= 1'b0;
            r_pp_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= r_pp_v && r_pp_last;
            if (i_start) begin
                r_cnt  <= CNT_W'(NCH);
                r_pp_v <= 1'b0;
            end else if (r_cnt != '0) begin
                r_cnt     <= r_cnt - CNT_W'(1);
                r_pp_v    <= 1'b1;
                r_pp_last <= (r_cnt == CNT_W'(1));
            end else begin
                r_pp_v <= 1'b0;
            end
        end
    end

    // operand shift, partial product register and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= w_a_ext;
            r_b   <= i_b;
            r_acc <= '0;
        end else begin
            if (r_cnt != '0) begin
                r_a  <= r_a <<< CW;
                r_pp <= w_pp;
            end
            if (r_pp_v) begin
                r_acc <= (r_acc <<< CW) + PW'(r_pp);
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    `PIDC_ASSERT_NOW(a_start_when_free, i_clk, i_rst_n, i_start, !w_busy, "multiplier restarted while busy")

endmodule

// ===== sv/pidc_dp.sv =====
// datapath: configuration, state, error and term arithmetic, output register
`include "pid_controller_step_assert.svh"

module pidc_dp #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 40,
    parameter int CFG_W       = 40
) (
    i_clk,
    i_rst_n,
    i_cfg_valid,
    i_cfg_index,
    i_cfg_data,
    i_measured,
    i_target,
    i_enable,
    i_cmd,
    o_status,
    o_drive,
    o_computed
);
    localparam int V   = VALUE_WIDTH;
    localparam int CW  = pidc_pkg::MUL_CW;
    localparam int BW  = pidc_pkg::MUL_BW;
    localparam int NCH = (V + CW - 1) / CW;
    localparam int PW  = NCH * CW + BW;
    localparam int WW  = PW + 2;
    localparam int GW  = pidc_pkg::GAIN_W;
    localparam int SW  = pidc_pkg::SCALE_W;

    localparam logic signed [V-1:0]  VMAX   = {1'b0, {(V-1){1'b1}}};
    localparam logic signed [V-1:0]  VMIN   = {1'b1, {(V-1){1'b0}}};
    localparam logic signed [WW-1:0] VMAX_W = WW'(VMAX);
    localparam logic signed [WW-1:0] VMIN_W = ~VMAX_W;
    localparam logic [63:0]          LIM_HI_FULL = 64'(pidc_pkg::LIM_HI_RST_INT) << FRAC_BITS;
    localparam logic [V-1:0]         LIM_HI_RST  = LIM_HI_FULL[V-1:0];
    localparam logic [SW-1:0]        SCALE_RST   = SW'(1) << FRAC_BITS;

    input  logic                                i_clk;
    input  logic                                i_rst_n;
    input  logic                                i_cfg_valid;
    input  logic [pidc_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    input  logic [CFG_W-1:0]                    i_cfg_data;
    input  logic signed [V-1:0]                 i_measured;
    input  logic signed [V-1:0]                 i_target;
    input  logic                                i_enable;
    input  pidc_pkg::t_dp_cmd                   i_cmd;
    output pidc_pkg::t_dp_status                o_status;
    output logic signed [V-1:0]                 o_drive;
    output logic                                o_computed;

    // configuration registers
    logic signed [GW-1:0] r_gain_p;
    logic signed [GW-1:0] r_gain_i;
    logic signed [GW-1:0] r_gain_d;
    logic signed [V-1:0]  r_lim_lo;
    logic signed [V-1:0]  r_lim_hi;
    logic                 r_pos;
    logic [V-2:0]         r_deadband;
    logic [SW-1:0]        r_scale;

    // controller state kept across samples
    logic signed [V-1:0]  r_integ;
    logic signed [V-1:0]  r_prev;
    logic signed [V-1:0]  r_held;

    // per-sample working registers
    logic signed [V-1:0]  r_meas;
    logic signed [V-1:0]  r_tgt;
    logic signed [V-1:0]  r_cur;
    logic signed [V-1:0]  r_old;
    logic signed [V-1:0]  r_err;
    logic signed [V-1:0]  r_dinp;
    logic                 r_zero;
    logic signed [WW-1:0] r_acc;
    logic signed [V-1:0]  r_res_drive;
    logic                 r_res_comp;
    logic signed [V-1:0]  r_o_drive;
    logic                 r_o_comp;

    logic signed [V-1:0]  w_mul_a;
    logic signed [BW-1:0] w_mul_b;
    logic                 w_mul_done;
    logic signed [PW-1:0] w_prod;
    logic signed [WW-1:0] w_prod_x;
    logic signed [WW-1:0] w_shp;
    logic signed [V-1:0]  w_shp_sat;
    logic signed [V:0]    w_diff_e;
    logic signed [V-1:0]  w_err_sat;
    logic signed [V:0]    w_err_x;
    logic signed [V:0]    w_db_x;
    logic                 w_in_band;
    logic signed [V-1:0]  w_err;
    logic signed [V:0]    w_diff_d;
    logic signed [V-1:0]  w_dinp;
    logic signed [WW-1:0] w_lo_w;
    logic signed [WW-1:0] w_hi_w;
    logic signed [WW-1:0] w_isum;
    logic signed [V-1:0]  w_integ_cl;
    logic signed [V-1:0]  w_drive;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_lim_lo   <= '0;
            r_lim_hi   <= LIM_HI_RST;
            r_pos      <= 1'b0;
            r_deadband <= '0;
            r_scale    <= SCALE_RST;
        end else if (i_cfg_valid) begin
            case (pidc_pkg::t_reg_idx'(i_cfg_index))
                pidc_pkg::REG_GAIN_PROP:     r_gain_p   <= i_cfg_data[GW-1:0];
                pidc_pkg::REG_GAIN_INTEG:    r_gain_i   <= i_cfg_data[GW-1:0];
                pidc_pkg::REG_GAIN_DERIV:    r_gain_d   <= i_cfg_data[GW-1:0];
                pidc_pkg::REG_LIMIT_LOW:     r_lim_lo   <= i_cfg_data[V-1:0];
                pidc_pkg::REG_LIMIT_HIGH:    r_lim_hi   <= i_cfg_data[V-1:0];
                pidc_pkg::REG_POSITION_MODE: r_pos      <= i_cfg_data[0];
                pidc_pkg::REG_DEADBAND:      r_deadband <= i_cfg_data[V-2:0];
                pidc_pkg::REG_COUNT_SCALE:   r_scale    <= i_cfg_data[SW-1:0];
                default: begin
                end
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            pidc_pkg::MS_CUR: begin
                w_mul_a = i_measured;
                w_mul_b = $signed({1'b0, r_scale});
            end
            pidc_pkg::MS_OLD: begin
                w_mul_a = r_prev;
                w_mul_b = $signed({1'b0, r_scale});
            end
            pidc_pkg::MS_INT: begin
                w_mul_a = w_err;
                w_mul_b = r_gain_i;
            end
            pidc_pkg::MS_PRO: begin
                w_mul_a = r_err;
                w_mul_b = r_gain_p;
            end
            pidc_pkg::MS_DER: begin
                w_mul_a = r_dinp;
                w_mul_b = r_gain_d;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    pidc_mul #(
        .A_W (V)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // product back to value scale, floor rounding
    assign w_prod_x  = WW'(w_prod);
    assign w_shp     = w_prod_x >>> FRAC_BITS;
    assign w_shp_sat = (w_shp > VMAX_W) ? VMAX : (w_shp < VMIN_W) ? VMIN : w_shp[V-1:0];

    // error with saturation, then strict deadband in position mode
    assign w_diff_e  = {r_tgt[V-1], r_tgt} - {r_cur[V-1], r_cur};
    assign w_err_sat = (w_diff_e[V] != w_diff_e[V-1]) ? (w_diff_e[V] ? VMIN : VMAX)
                                                      : w_diff_e[V-1:0];
    assign w_err_x   = {w_err_sat[V-1], w_err_sat};
    assign w_db_x    = $signed({2'b00, r_deadband});
    assign w_in_band = r_pos && (w_err_x < w_db_x) && (w_err_x > -w_db_x);
    assign w_err     = w_in_band ? '0 : w_err_sat;

    // measurement difference with saturation
    assign w_diff_d = {r_cur[V-1], r_cur} - {r_old[V-1], r_old};
    assign w_dinp   = (w_diff_d[V] != w_diff_d[V-1]) ? (w_diff_d[V] ? VMIN : VMAX)
                                                     : w_diff_d[V-1:0];

    // clamps: above the upper limit wins over below the lower limit
    assign w_lo_w     = WW'(r_lim_lo);
    assign w_hi_w     = WW'(r_lim_hi);
    assign w_isum     = WW'(r_integ) + w_shp;
    assign w_integ_cl = (w_isum > w_hi_w) ? r_lim_hi
                      : (w_isum < w_lo_w) ? r_lim_lo : w_isum[V-1:0];
    assign w_drive    = (r_acc > w_hi_w) ? r_lim_hi
                      : (r_acc < w_lo_w) ? r_lim_lo : r_acc[V-1:0];

    // state that persists across samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
            r_held  <= '0;
        end else begin
            if (i_cmd.cap_integ) begin
                r_integ <= w_integ_cl;
            end
            if (i_cmd.finish) begin
                r_prev <= r_meas;
                r_held <= w_drive;
            end
        end
    end

    // per-sample working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_meas      <= i_measured;
            r_tgt       <= i_target;
            r_cur       <= i_measured;
            r_old       <= r_prev;
            r_res_drive <= r_held;
            r_res_comp  <= 1'b0;
        end
        if (i_cmd.cap_cur) begin
            r_cur <= w_shp_sat;
        end
        if (i_cmd.cap_old) begin
            r_old <= w_shp_sat;
        end
        if (i_cmd.cap_err) begin
            r_err  <= w_err;
            r_dinp <= w_dinp;
            r_zero <= r_pos && (w_err == '0);
        end
        if (i_cmd.clear_acc) begin
            r_acc <= '0;
        end else if (i_cmd.cap_prop) begin
            r_acc <= w_shp + WW'(r_integ);
        end else if (i_cmd.cap_deriv) begin
            r_acc <= r_acc - w_shp;
        end
        if (i_cmd.finish) begin
            r_res_drive <= w_drive;
            r_res_comp  <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_o_drive <= r_res_drive;
            r_o_comp  <= r_res_comp;
        end
    end

    assign o_status.mul_done = w_mul_done;
    assign o_status.enable   = i_enable;
    assign o_status.pos_mode = r_pos;
    assign o_status.err_zero = r_zero;

    assign o_drive    = r_o_drive;
    assign o_computed = r_o_comp;

    `PIDC_ASSERT_NOW(a_drive_in_limits, i_clk, i_rst_n, i_cmd.finish && (r_lim_lo <= r_lim_hi), (w_drive >= r_lim_lo) && (w_drive <= r_lim_hi), "drive outside ordered limits")

endmodule

// ===== sv/pidc_ctrl.sv =====
// controller state machine: sequences the multiplies and the handshakes
`include "pid_controller_step_assert.svh"

module pidc_ctrl (
    i_clk,
    i_rst_n,
    i_in_valid,
    o_in_ready,
    o_out_valid,
    i_out_ready,
    i_status,
    o_cmd
);
    input  logic                 i_clk;
    input  logic                 i_rst_n;
    input  logic                 i_in_valid;
    output logic                 o_in_ready;
    output logic                 o_out_valid;
    input  logic                 i_out_ready;
    input  pidc_pkg::t_dp_status i_status;
    output pidc_pkg::t_dp_cmd    o_cmd;

    pidc_pkg::t_state  r_state;
    pidc_pkg::t_state  n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    pidc_pkg::t_dp_cmd w_cmd;
    logic              w_accept;

    assign o_in_ready = (r_state == pidc_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        w_cmd         = '0;
        w_cmd.mul_sel = pidc_pkg::MS_CUR;
        case (r_state)
            pidc_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_cmd.load_in = 1'b1;
                    if (!i_status.enable) begin
                        n_state = pidc_pkg::S_OUT;
                    end else if (i_status.pos_mode) begin
                        w_cmd.mul_start = 1'b1;
                        w_cmd.mul_sel   = pidc_pkg::MS_CUR;
                        n_state         = pidc_pkg::S_W_CUR;
                    end else begin
                        n_state = pidc_pkg::S_ERR;
                    end
                end
            end
            pidc_pkg::S_W_CUR: begin
                if (i_status.mul_done) begin
                    w_cmd.cap_cur   = 1'b1;
                    w_cmd.mul_start = 1'b1;
                    w_cmd.mul_sel   = pidc_pkg::MS_OLD;
                    n_state         = pidc_pkg::S_W_OLD;
                end
            end
            pidc_pkg::S_W_OLD: begin
                if (i_status.mul_done) begin
                    w_cmd.cap_old = 1'b1;
                    n_state       = pidc_pkg::S_ERR;
                end
            end
            pidc_pkg::S_ERR: begin
                w_cmd.cap_err   = 1'b1;
                w_cmd.mul_start = 1'b1;
                w_cmd.mul_sel   = pidc_pkg::MS_INT;
                n_state         = pidc_pkg::S_W_INT;
            end
            pidc_pkg::S_W_INT: begin
                if (i_status.mul_done) begin
                    w_cmd.cap_integ = 1'b1;
                    // zero error in position mode: sum forced to zero before the clamp
                    if (i_status.err_zero) begin
                        w_cmd.clear_acc = 1'b1;
                        n_state         = pidc_pkg::S_SUM;
                    end else begin
                        w_cmd.mul_start = 1'b1;
                        w_cmd.mul_sel   = pidc_pkg::MS_PRO;
                        n_state         = pidc_pkg::S_W_PRO;
                    end
                end
            end
            pidc_pkg::S_W_PRO: begin
                if (i_status.mul_done) begin
                    w_cmd.cap_prop  = 1'b1;
                    w_cmd.mul_start = 1'b1;
                    w_cmd.mul_sel   = pidc_pkg::MS_DER;
                    n_state         = pidc_pkg::S_W_DER;
                end
            end
            pidc_pkg::S_W_DER: begin
                if (i_status.mul_done) begin
                    w_cmd.cap_deriv = 1'b1;
                    n_state         = pidc_pkg::S_SUM;
                end
            end
            pidc_pkg::S_SUM: begin
                w_cmd.finish = 1'b1;
                n_state      = pidc_pkg::S_OUT;
            end
            pidc_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = pidc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pidc_pkg::S_IDLE;
            end
        endcase
    end

    // output beat pending flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pidc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    `PIDC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, r_state != pidc_pkg::S_IDLE, "accepted beat left controller idle")
    `PIDC_ASSERT_NEXT(a_sum_then_out, i_clk, i_rst_n, r_state == pidc_pkg::S_SUM, r_state == pidc_pkg::S_OUT, "sum step not followed by output step")
    `PIDC_ASSERT_NOW(a_out_from_out_state, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == pidc_pkg::S_OUT), "output beat raised outside output step")

endmodule

// ===== sv/pid_controller_step.sv =====
// top level of the pid controller step: controller plus datapath
//
// channel  dir  handshake                  payload
// in       in   i_in_valid / o_in_ready    i_measured, i_target, i_enable
// out      out  o_out_valid / i_out_ready  o_drive, o_computed
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one sample at a time; all products go through one sliced 32x32 multiplier,
// NCH = ceil(VALUE_WIDTH/31) slices per product; disabled beat: the held drive
// with no products; speed mode: 3 products; position mode adds 2 scaling
// products and skips p and d when the error is zero; a new beat is taken as soon
// as the last result sits in the output register; reset is synchronous active
// low; cfg is always ready and is to be written when idle, not enforced by the block
module pid_controller_step #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 40,
    localparam int CFG_W = (VALUE_WIDTH > pidc_pkg::GAIN_W) ? VALUE_WIDTH : pidc_pkg::GAIN_W
) (
    i_clk,
    i_rst_n,
    i_cfg_valid,
    o_cfg_ready,
    i_cfg_index,
    i_cfg_data,
    i_in_valid,
    o_in_ready,
    i_measured,
    i_target,
    i_enable,
    o_out_valid,
    i_out_ready,
    o_drive,
    o_computed
);
    input  logic                             i_clk;
    input  logic                             i_rst_n;
    input  logic                             i_cfg_valid;
    output logic                             o_cfg_ready;
    input  logic [pidc_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    input  logic [CFG_W-1:0]                 i_cfg_data;
    input  logic                             i_in_valid;
    output logic                             o_in_ready;
    input  logic signed [VALUE_WIDTH-1:0]    i_measured;
    input  logic signed [VALUE_WIDTH-1:0]    i_target;
    input  logic                             i_enable;
    output logic                             o_out_valid;
    input  logic                             i_out_ready;
    output logic signed [VALUE_WIDTH-1:0]    o_drive;
    output logic                             o_computed;

    pidc_pkg::t_dp_cmd    w_cmd;
    pidc_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    pidc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pidc_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CFG_W       (CFG_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_measured  (i_measured),
        .i_target    (i_target),
        .i_enable    (i_enable),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_drive     (o_drive),
        .o_computed  (o_computed)
    );

endmodule

// ===== tb/tb_pid_controller_step.sv =====
// self-checking testbench for the pid controller step: directed, random and backpressure tests
`timescale 1ns / 1ps

module tb_pid_controller_step;

    localparam int FB             = 16;
    localparam int VW             = 40;
    localparam int CFG_W          = 40;
    localparam int HALF_PERIOD    = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF       = 300;
    localparam int PHASE_ITEMS    = 150;
    localparam int PHASES         = 12;
    localparam int MAX_GAP        = 19;

    typedef logic signed [VW-1:0] t_val;
    typedef logic signed [95:0]   t_wide;
    typedef struct packed {
        t_val drive;
        logic computed;
    } t_pid_result;

    localparam t_val  VAL_HI   = {1'b0, {(VW-1){1'b1}}};
    localparam t_val  VAL_LO   = {1'b1, {(VW-1){1'b0}}};
    localparam t_wide W_VAL_HI = VAL_HI;
    localparam t_wide W_VAL_LO = VAL_LO;

    // dut ports
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    pidc_pkg::t_reg_idx  i_cfg_index = pidc_pkg::REG_GAIN_PROP;
    logic [CFG_W-1:0]    i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_val                i_measured  = '0;
    t_val                i_target    = '0;
    logic                i_enable    = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_val                o_drive;
    logic                o_computed;

    // predictor copy of the tuning registers
    logic signed [31:0] kp, ki, kd;
    t_val               out_lo, out_hi;
    logic               pos_mode;
    logic [VW-2:0]      tol_band;
    logic [30:0]        enc_scale;

    // predictor copy of the loop state
    t_val acc_integral = '0;
    t_val last_meas    = '0;
    t_val last_drive   = '0;

    t_pid_result      expected_q[$];
    logic [CFG_W-1:0] tuning [8];
    int               fail_count   = 0;
    int               quiet_cycles = 0;
    int               stall_left   = 0;
    int               hold_left    = 0;
    bit               send_gaps_on = 1'b1;
    bit               recv_gaps_on = 1'b1;

    pid_controller_step u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_measured  (i_measured),
        .i_target    (i_target),
        .i_enable    (i_enable),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive     (o_drive),
        .o_computed  (o_computed)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // register values after reset
    initial begin
        kp        = '0;
        ki        = '0;
        kd        = '0;
        out_lo    = '0;
        out_hi    = {8'h00, pidc_pkg::LIM_HI_RST_INT, 16'h0000};
        pos_mode  = 1'b0;
        tol_band  = '0;
        enc_scale = 31'h0001_0000;
    end

    function automatic void load_tuning_reg(input pidc_pkg::t_reg_idx idx,
                                            input logic [CFG_W-1:0] data);
        case (idx)
            pidc_pkg::REG_GAIN_PROP:     kp        = data[31:0];
            pidc_pkg::REG_GAIN_INTEG:    ki        = data[31:0];
            pidc_pkg::REG_GAIN_DERIV:    kd        = data[31:0];
            pidc_pkg::REG_LIMIT_LOW:     out_lo    = data[VW-1:0];
            pidc_pkg::REG_LIMIT_HIGH:    out_hi    = data[VW-1:0];
            pidc_pkg::REG_POSITION_MODE: pos_mode  = data[0];
            pidc_pkg::REG_DEADBAND:      tol_band  = data[VW-2:0];
            pidc_pkg::REG_COUNT_SCALE:   enc_scale = data[30:0];
            default: ;
        endcase
    endfunction

    // exact product, then floor shift back to the value scale
    function automatic t_wide fx_mul(input t_wide a, input t_wide b);
        return (a * b) >>> FB;
    endfunction

    function automatic t_val sat_value(input t_wide a);
        if (a > W_VAL_HI) return VAL_HI;
        if (a < W_VAL_LO) return VAL_LO;
        return a[VW-1:0];
    endfunction

    // high limit wins over low limit when they cross
    function automatic t_val clamp_out(input t_wide a);
        t_wide lo_w, hi_w;
        lo_w = out_lo;
        hi_w = out_hi;
        if (a > hi_w) return out_hi;
        if (a < lo_w) return out_lo;
        return a[VW-1:0];
    endfunction

    function automatic t_val scale_counts(input t_val v);
        t_wide s;
        s = {65'b0, enc_scale};
        return sat_value(fx_mul(v, s));
    endfunction

    function automatic void predict_pid_output(input t_val meas, input t_val tgt,
                                               input logic en, output t_pid_result res);
        t_wide cur, old, err, dinp, acc, band, tgt_w, integ_w;
        if (!en) begin
            res.drive    = last_drive;
            res.computed = 1'b0;
            return;
        end
        if (pos_mode) begin
            cur = scale_counts(meas);
            old = scale_counts(last_meas);
        end else begin
            cur = meas;
            old = last_meas;
        end
        tgt_w = tgt;
        err   = sat_value(tgt_w - cur);
        band  = {57'b0, tol_band};
        // strict tolerance band around the target
        if (pos_mode && err < band && err > -band)
            err = 0;
        integ_w      = acc_integral;
        acc_integral = clamp_out(integ_w + fx_mul(ki, err));
        dinp         = sat_value(cur - old);
        // zero error in position mode forces zero before the clamp
        if (pos_mode && err == 0) begin
            acc = 0;
        end else begin
            integ_w = acc_integral;
            acc     = fx_mul(kp, err) + integ_w - fx_mul(kd, dinp);
        end
        last_drive   = clamp_out(acc);
        last_meas    = meas;
        res.drive    = last_drive;
        res.computed = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // monitors and checker
    // ---------------------------------------------------------------

    function automatic void log_failure(input string msg);
        if (fail_count < 10)
            $display("%s", msg);
        fail_count++;
    endfunction

    // sample every accepted beat at the rising edge
    always @(posedge i_clk) begin
        t_pid_result want, got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                load_tuning_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                predict_pid_output(i_measured, i_target, i_enable, want);
                expected_q.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                got.drive    = o_drive;
                got.computed = o_computed;
                stall_left   = recv_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
                if (expected_q.size() == 0) begin
                    log_failure($sformatf("unexpected result: drive %0d computed %b",
                                          got.drive, got.computed));
                end else begin
                    want = expected_q.pop_front();
                    if (got.drive !== want.drive || got.computed !== want.computed)
                        log_failure($sformatf(
                            "mismatch: drive exp %0d got %0d, computed exp %b got %b",
                            want.drive, got.drive, want.computed, got.computed));
                end
            end
        end
    end

    // receiver: per-result stall plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left   = hold_left - 1;
        end else if (stall_left > 0) begin
            i_out_ready = 1'b0;
            stall_left  = stall_left - 1;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    task automatic send_sample(input t_val meas, input t_val tgt, input logic en);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_measured = meas;
        i_target   = tgt;
        i_enable   = en;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop offering samples and wait for every result
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input pidc_pkg::t_reg_idx idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_tuning();
        wait_idle();
        for (int i = 0; i < 8; i++)
            write_reg(pidc_pkg::t_reg_idx'(i), tuning[i]);
    endtask

    function automatic t_val to_fix(input int units);
        return t_val'(units) <<< FB;
    endfunction

    // value mix: full range, extremes and a few magnitudes
    function automatic t_val rand_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1: return r[VW-1:0];
            2: begin
                case ($urandom_range(0, 4))
                    0: return VAL_HI;
                    1: return VAL_LO;
                    2: return '0;
                    3: return t_val'(1);
                    default: return -t_val'(1);
                endcase
            end
            3: return $signed(r[24:0]);
            4: return $signed(r[32:0]);
            default: return $signed(r[20:0]);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_gain_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return {r[39:32], 32'h7fff_ffff};
            1: return {r[39:32], 32'h8000_0000};
            2: return {r[39:32], 32'h0000_0000};
            3: return r[39:0];
            default: return {{21{r[18]}}, r[18:0]};
        endcase
    endfunction

    function automatic void randomize_tuning();
        logic [63:0] r;
        t_val        a, b, t;
        r = {$urandom, $urandom};
        tuning[pidc_pkg::REG_GAIN_PROP]  = rand_gain_word();
        tuning[pidc_pkg::REG_GAIN_INTEG] = rand_gain_word();
        tuning[pidc_pkg::REG_GAIN_DERIV] = rand_gain_word();
        a = rand_value();
        b = rand_value();
        if (a > b) begin
            t = a;
            a = b;
            b = t;
        end
        // output limits: full range, narrow band, random, crossed, zero to positive
        case ($urandom_range(0, 4))
            0: begin
                a = VAL_LO;
                b = VAL_HI;
            end
            1: begin
                a = -t_val'($urandom_range(1, 32'h0400_0000));
                b = t_val'($urandom_range(1, 32'h0400_0000));
            end
            2: ;
            3: begin
                t = a;
                a = b;
                b = t;
            end
            default: begin
                a = '0;
                b = t_val'($urandom_range(1, 32'hffff_0000));
            end
        endcase
        tuning[pidc_pkg::REG_LIMIT_LOW]     = a;
        tuning[pidc_pkg::REG_LIMIT_HIGH]    = b;
        tuning[pidc_pkg::REG_POSITION_MODE] = r[39:0];
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: tuning[pidc_pkg::REG_DEADBAND] = {r[39], 39'h0};
            1: tuning[pidc_pkg::REG_DEADBAND] = {r[39:18], r[17:0]} & 40'h80_0003_ffff;
            2: tuning[pidc_pkg::REG_DEADBAND] = {r[39], {(VW-1){1'b1}}};
            default: tuning[pidc_pkg::REG_DEADBAND] = r[39:0];
        endcase
        r = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: tuning[pidc_pkg::REG_COUNT_SCALE] = {r[39:31], 31'h0001_0000};
            1: tuning[pidc_pkg::REG_COUNT_SCALE] = {r[39:31], 31'h7fff_ffff};
            2: tuning[pidc_pkg::REG_COUNT_SCALE] = {r[39:31], 31'h0};
            3: tuning[pidc_pkg::REG_COUNT_SCALE] = r[39:0];
            default: tuning[pidc_pkg::REG_COUNT_SCALE] = {r[39:31], 13'b0, r[17:0]};
        endcase
    endfunction

    // mostly a closed loop around the predicted drive, with jumps and noise
    task automatic run_random_phase(input int count);
        t_val        meas, tgt, noise;
        logic [63:0] r;
        meas = rand_value();
        tgt  = rand_value();
        for (int k = 0; k < count; k++) begin
            r     = {$urandom, $urandom};
            noise = $signed(r[15:0]);
            case ($urandom_range(0, 9))
                0: meas = rand_value();
                1: tgt = rand_value();
                2: begin
                    meas = r[39:0];
                    tgt  = rand_value();
                end
                default: meas = meas + (last_drive >>> 4) + noise;
            endcase
            send_sample(meas, tgt, $urandom_range(0, 7) != 0);
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // tuning after reset: zero gains, limits 0 .. 65535
    task automatic test_reset_state();
        send_sample(to_fix(3), to_fix(1), 1'b0);
        send_sample(to_fix(100), to_fix(50), 1'b1);
        send_sample(VAL_HI, VAL_LO, 1'b1);
    endtask

    // speed mode: saturated error and derivative, disabled hold, zero error
    task automatic test_speed_mode();
        tuning[pidc_pkg::REG_GAIN_PROP]     = 40'h00_0001_0000;
        tuning[pidc_pkg::REG_GAIN_INTEG]    = 40'h00_0000_4000;
        tuning[pidc_pkg::REG_GAIN_DERIV]    = 40'hff_ffff_8000;
        tuning[pidc_pkg::REG_LIMIT_LOW]     = to_fix(-1000);
        tuning[pidc_pkg::REG_LIMIT_HIGH]    = to_fix(1000);
        tuning[pidc_pkg::REG_POSITION_MODE] = 40'h0;
        tuning[pidc_pkg::REG_DEADBAND]      = 40'h0;
        tuning[pidc_pkg::REG_COUNT_SCALE]   = 40'h00_0001_0000;
        write_tuning();
        send_sample(to_fix(10), to_fix(12) + t_val'(32'h8000), 1'b1);
        send_sample(VAL_HI, VAL_LO, 1'b1);
        send_sample(VAL_LO, VAL_HI, 1'b1);
        send_sample(to_fix(3), to_fix(3), 1'b0);
        send_sample(to_fix(5), to_fix(5), 1'b1);
        send_sample(to_fix(-5), to_fix(7), 1'b1);
    endtask

    // position mode: band edges, scale saturation, floor rounding
    task automatic test_position_mode();
        tuning[pidc_pkg::REG_GAIN_PROP]     = 40'h00_0002_0000;
        tuning[pidc_pkg::REG_GAIN_INTEG]    = 40'hff_ffff_0000;
        tuning[pidc_pkg::REG_GAIN_DERIV]    = 40'h00_7fff_ffff;
        tuning[pidc_pkg::REG_LIMIT_LOW]     = VAL_LO;
        tuning[pidc_pkg::REG_LIMIT_HIGH]    = VAL_HI;
        tuning[pidc_pkg::REG_POSITION_MODE] = 40'h1;
        tuning[pidc_pkg::REG_DEADBAND]      = 40'h00_0000_8000;
        tuning[pidc_pkg::REG_COUNT_SCALE]   = 40'h00_0001_8000;
        write_tuning();
        send_sample(to_fix(10), to_fix(15) + t_val'(32'h4000), 1'b1);
        send_sample(to_fix(10), to_fix(15) + t_val'(32'h8000), 1'b1);
        send_sample(to_fix(10), to_fix(14) + t_val'(32'h8000), 1'b1);
        send_sample(VAL_HI, '0, 1'b1);
        send_sample(VAL_LO, VAL_LO, 1'b1);
        send_sample(-t_val'(1), '0, 1'b1);
    endtask

    // crossed limits and forced zero lifted to a positive low limit
    task automatic test_limit_order();
        tuning[pidc_pkg::REG_GAIN_PROP]     = 40'h00_0001_0000;
        tuning[pidc_pkg::REG_GAIN_INTEG]    = 40'h0;
        tuning[pidc_pkg::REG_GAIN_DERIV]    = 40'h0;
        tuning[pidc_pkg::REG_LIMIT_LOW]     = to_fix(5);
        tuning[pidc_pkg::REG_LIMIT_HIGH]    = to_fix(2);
        tuning[pidc_pkg::REG_POSITION_MODE] = 40'h1;
        tuning[pidc_pkg::REG_DEADBAND]      = 40'h0;
        tuning[pidc_pkg::REG_COUNT_SCALE]   = 40'h0;
        write_tuning();
        send_sample(to_fix(7), '0, 1'b1);
        send_sample('0, to_fix(100), 1'b1);
        send_sample('0, to_fix(-100), 1'b1);
    endtask

    // random tuning per phase, extremes first, idling varied per phase
    task automatic test_random_tuning();
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                tuning[pidc_pkg::REG_GAIN_PROP]     = 40'h00_7fff_ffff;
                tuning[pidc_pkg::REG_GAIN_INTEG]    = 40'h00_7fff_ffff;
                tuning[pidc_pkg::REG_GAIN_DERIV]    = 40'h00_7fff_ffff;
                tuning[pidc_pkg::REG_LIMIT_LOW]     = VAL_LO;
                tuning[pidc_pkg::REG_LIMIT_HIGH]    = VAL_HI;
                tuning[pidc_pkg::REG_POSITION_MODE] = 40'hff_ffff_ffff;
                tuning[pidc_pkg::REG_DEADBAND]      = 40'hff_ffff_ffff;
                tuning[pidc_pkg::REG_COUNT_SCALE]   = 40'hff_ffff_ffff;
            end else if (p == 1) begin
                tuning[pidc_pkg::REG_GAIN_PROP]     = 40'hff_8000_0000;
                tuning[pidc_pkg::REG_GAIN_INTEG]    = 40'hff_8000_0000;
                tuning[pidc_pkg::REG_GAIN_DERIV]    = 40'hff_8000_0000;
                tuning[pidc_pkg::REG_LIMIT_LOW]     = VAL_LO;
                tuning[pidc_pkg::REG_LIMIT_HIGH]    = VAL_HI;
                tuning[pidc_pkg::REG_POSITION_MODE] = 40'hff_ffff_fffe;
                tuning[pidc_pkg::REG_DEADBAND]      = 40'h0;
                tuning[pidc_pkg::REG_COUNT_SCALE]   = 40'h0;
            end else begin
                randomize_tuning();
            end
            write_tuning();
            send_gaps_on = (p % 3) != 0;
            recv_gaps_on = (p % 4) != 1;
            run_random_phase(PHASE_ITEMS);
        end
    endtask

    // long receiver hold-off while samples keep coming back to back
    task automatic test_backpressure();
        wait_idle();
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b0;
        hold_left    = HOLD_OFF;
        run_random_phase(30);
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_state();
        test_speed_mode();
        test_position_mode();
        test_limit_order();
        test_backpressure();
        test_random_tuning();
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/pidc_pkg.sv
sv/pidc_mul.sv
sv/pidc_dp.sv
sv/pidc_ctrl.sv
sv/pid_controller_step.sv
tb/tb_pid_controller_step.sv
